[sv/sun_acquisition_controller_assert.svh]
// Assertion macros for the checker module of the sun acquisition controller.
// Depends on a clk_i and an active-low rst_ni in the scope where a macro is used.
`ifndef SUN_ACQUISITION_CONTROLLER_ASSERT_SVH
`define SUN_ACQUISITION_CONTROLLER_ASSERT_SVH

// Consequent must hold in the clock after the antecedent.
`define SAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sun acquisition controller: assertion failed");

// Consequent must hold in the same clock as the antecedent.
`define SAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sun acquisition controller: assertion failed");

`endif

[sv/sac_pkg.sv]
// Package of the sun acquisition controller: field widths, register indexes,
// reset values, request and result structs, saturation helpers. No dependencies.
`default_nettype none

package sac_pkg;

  localparam int VALUE_W    = 24;
  localparam int RATE_CFG_W = 23;
  localparam int ANGLE_CFG_W = 25;
  localparam int GAIN_W     = 24;
  localparam int FLIP_W     = 8;
  localparam int LOSS_W     = 16;
  localparam int MODE_W     = 2;
  localparam int ANGLE_W    = 32;
  localparam int CMD_W      = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int SCAN_SHIFT = 24;
  localparam int TRAV_SHIFT = 20;
  localparam int SUN_FRAC   = 22;

  localparam logic [RATE_CFG_W-1:0]  MAX_RATE_RST      = RATE_CFG_W'(36602);
  localparam logic [RATE_CFG_W-1:0]  POINTING_GAIN_RST = RATE_CFG_W'(36602);
  localparam logic [RATE_CFG_W-1:0]  REST_RATE_RST     = RATE_CFG_W'(732);
  localparam logic [ANGLE_CFG_W-1:0] SCAN_START_RST    = ANGLE_CFG_W'(11796480);
  localparam logic [GAIN_W-1:0]      SCAN_GAIN_RST     = GAIN_W'(312340);
  localparam logic [GAIN_W-1:0]      ANGLE_PER_TICK_RST = GAIN_W'(375494);
  localparam logic [FLIP_W-1:0]      FLIP_INTERVAL_RST = FLIP_W'(5);

  localparam logic signed [ANGLE_W-1:0] SCAN_DONE_ANGLE = ANGLE_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RATE,
    REG_POINTING_GAIN,
    REG_REST_RATE,
    REG_SCAN_START_ANGLE,
    REG_SCAN_GAIN,
    REG_ANGLE_PER_RATE_TICK,
    REG_FLIP_INTERVAL
  } cfg_reg_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sun_x;
    logic signed [VALUE_W-1:0] sun_y;
    logic signed [VALUE_W-1:0] rate_x;
    logic signed [VALUE_W-1:0] rate_y;
    logic signed [VALUE_W-1:0] rate_z;
    logic                      sun_seen;
  } sac_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cmd_x;
    logic signed [VALUE_W-1:0] cmd_y;
    logic signed [VALUE_W-1:0] cmd_z;
    logic [MODE_W-1:0]         mode_now;
    logic                      sun_echo;
    logic [LOSS_W-1:0]         loss_count;
  } sac_out_t;

  function automatic logic [VALUE_W-1:0] abs_val(input logic signed [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? VALUE_W'(-v) : VALUE_W'(v);
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_cmd(input logic signed [CMD_W-1:0] v);
    logic [CMD_W-VALUE_W:0] top;
    top = v[CMD_W-1:VALUE_W-1];
    if (top == '0 || top == '1) begin
      return v[VALUE_W-1:0];
    end else if (v[CMD_W-1]) begin
      return {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_W-1){1'b1}}};
    end
  endfunction

  function automatic logic [FLIP_W-1:0] inc_sat8(input logic [FLIP_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

[sv/sun_acquisition_controller.sv]
// Sun acquisition controller, top level: input register, mode logic, result register.
// Depends on sac_pkg.
//
// Usage:
//  - Input channel in_valid_i/in_ready_o/in_data_i carries one sensor tick per request:
//    sun vector x/y, body rates x/y/z and the sun-seen flag.
//  - Output channel out_valid_o/out_ready_i/out_data_o returns one result per tick:
//    rate commands x/y/z, mode after the tick, echoed sun flag and loss count.
//  - Configuration channel cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i is always
//    ready; write it only while no request is in flight. Unknown indexes are ignored.
//  - Path: an accepted request is captured in the input register and its result is
//    loaded into the result register when that register is free or out_ready_i is high;
//    out_valid_o is driven from the result register.
//  - Throughput: one request per cycle while the result drains; the whole tick (four multipliers of up to 32 by
//    25 bits, clamp and state update) is one combinational pass between the registers.
//  - Stall: while out_ready_i is low the result holds and one more request is taken
//    into the input register; then in_ready_o drops until the result drains.
//  - Reset: mode rest, scan angle 180 degrees, both axis signs negative, all counters
//    and registers at their default values, both channels empty.
`default_nettype none

module sun_acquisition_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire sac_pkg::sac_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output sac_pkg::sac_out_t                    out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sac_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sac_pkg::*;

  localparam int PROD_W = 2 * VALUE_W;
  localparam int SCAN_PROD_W = ANGLE_W + GAIN_W + 1;
  localparam int SPD_W = SCAN_PROD_W - SCAN_SHIFT;
  localparam int TRAV_PROD_W = VALUE_W + GAIN_W;
  localparam int TRAV_W = TRAV_PROD_W - TRAV_SHIFT;
  localparam int PNT_W = PROD_W - SUN_FRAC;

  typedef enum logic [MODE_W-1:0] {
    MODE_REST,
    MODE_SCAN,
    MODE_SPIN,
    MODE_POINT
  } mode_e;

  logic [RATE_CFG_W-1:0]  max_rate_q;
  logic [RATE_CFG_W-1:0]  pointing_gain_q;
  logic [RATE_CFG_W-1:0]  rest_rate_q;
  logic [GAIN_W-1:0]      scan_gain_q;
  logic [GAIN_W-1:0]      angle_per_tick_q;
  logic [FLIP_W-1:0]      flip_interval_q;

  logic    in_vld_q;
  sac_in_t in_q;
  logic    out_vld_q;
  sac_out_t out_q, out_d;
  logic    advance;

  mode_e                     mode_q, mode_d;
  logic signed [ANGLE_W-1:0] scan_angle_q, scan_angle_d;
  logic signed [VALUE_W-1:0] prev_sx_q, prev_sy_q, prev_rx_q, prev_ry_q;
  logic signed [VALUE_W-1:0] prev_sx_d, prev_sy_d, prev_rx_d, prev_ry_d;
  logic [FLIP_W-1:0]         tick_q, tick_d, evx_q, evx_d, evy_q, evy_d;
  logic                      neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [LOSS_W-1:0]         losses_q, losses_d;

  logic [VALUE_W-1:0] sx_abs, sy_abs, rx_abs, ry_abs, rz_abs;
  logic [VALUE_W-1:0] psx_abs, psy_abs, prx_abs, pry_abs;
  logic signed [SCAN_PROD_W-1:0] scan_prod;
  logic signed [SPD_W-1:0]       spd;
  logic [TRAV_PROD_W-1:0]        trav_prod;
  logic [TRAV_W-1:0]             trav;
  logic signed [ANGLE_W:0]       angle_diff;
  logic signed [ANGLE_W-1:0]     angle_new;
  logic signed [PROD_W-1:0]      prod_px, prod_py;
  logic signed [PNT_W-1:0]       p_val, q_val;
  logic signed [CMD_W-1:0]       mx_ext, spd_ext, p_ext, q_ext, cx_lin, cy_lin, cx, cy;
  logic                          same_dir, ev_x, ev_y, check;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q       <= MAX_RATE_RST;
      pointing_gain_q  <= POINTING_GAIN_RST;
      rest_rate_q      <= REST_RATE_RST;
      scan_gain_q      <= SCAN_GAIN_RST;
      angle_per_tick_q <= ANGLE_PER_TICK_RST;
      flip_interval_q  <= FLIP_INTERVAL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAX_RATE:            max_rate_q       <= cfg_data_i[RATE_CFG_W-1:0];
        REG_POINTING_GAIN:       pointing_gain_q  <= cfg_data_i[RATE_CFG_W-1:0];
        REG_REST_RATE:           rest_rate_q      <= cfg_data_i[RATE_CFG_W-1:0];
        // hold the running scan angle; only reset loads the start angle
        REG_SCAN_START_ANGLE:    ;
        REG_SCAN_GAIN:           scan_gain_q      <= cfg_data_i[GAIN_W-1:0];
        REG_ANGLE_PER_RATE_TICK: angle_per_tick_q <= cfg_data_i[GAIN_W-1:0];
        REG_FLIP_INTERVAL:       flip_interval_q  <= cfg_data_i[FLIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assign sx_abs  = abs_val(in_q.sun_x);
  assign sy_abs  = abs_val(in_q.sun_y);
  assign rx_abs  = abs_val(in_q.rate_x);
  assign ry_abs  = abs_val(in_q.rate_y);
  assign rz_abs  = abs_val(in_q.rate_z);
  assign psx_abs = abs_val(prev_sx_q);
  assign psy_abs = abs_val(prev_sy_q);
  assign prx_abs = abs_val(prev_rx_q);
  assign pry_abs = abs_val(prev_ry_q);

  assign scan_prod = scan_angle_q * $signed({1'b0, scan_gain_q});
  assign spd       = scan_prod[SCAN_PROD_W-1:SCAN_SHIFT];
  assign trav_prod = ry_abs * angle_per_tick_q;
  assign trav      = trav_prod[TRAV_PROD_W-1:TRAV_SHIFT];
  assign angle_diff = (ANGLE_W+1)'(scan_angle_q) - (ANGLE_W+1)'(trav);
  assign angle_new = (angle_diff[ANGLE_W] && !angle_diff[ANGLE_W-1]) ?
                     {1'b1, {(ANGLE_W-1){1'b0}}} : angle_diff[ANGLE_W-1:0];

  assign prod_px = $signed({1'b0, pointing_gain_q}) * in_q.sun_y;
  assign prod_py = $signed({1'b0, pointing_gain_q}) * in_q.sun_x;
  assign p_val   = prod_px[PROD_W-1:SUN_FRAC];
  assign q_val   = prod_py[PROD_W-1:SUN_FRAC];
  assign mx_ext  = CMD_W'(max_rate_q);
  assign spd_ext = CMD_W'(spd);
  assign p_ext   = CMD_W'(p_val);
  assign q_ext   = CMD_W'(q_val);

  always_comb begin
    if (p_ext > mx_ext) begin
      cx_lin = mx_ext;
    end else if (p_ext < -mx_ext) begin
      cx_lin = -mx_ext;
    end else begin
      cx_lin = -p_ext;
    end
    if (q_ext > mx_ext) begin
      cy_lin = mx_ext;
    end else if (q_ext < -mx_ext) begin
      cy_lin = -mx_ext;
    end else begin
      cy_lin = q_ext;
    end
  end

  assign same_dir = (!prev_ry_q[VALUE_W-1] && prev_ry_q != '0 &&
                     !in_q.rate_y[VALUE_W-1] && in_q.rate_y != '0) ||
                    (prev_ry_q[VALUE_W-1] && in_q.rate_y[VALUE_W-1]);
  assign check = tick_q >= flip_interval_q;
  assign ev_y  = check && sx_abs > psx_abs && pry_abs < ry_abs && same_dir;
  assign ev_x  = check && sy_abs > psy_abs && prx_abs < rx_abs && same_dir;

  always_comb begin
    mode_d       = mode_q;
    scan_angle_d = scan_angle_q;
    prev_sx_d    = prev_sx_q;
    prev_sy_d    = prev_sy_q;
    prev_rx_d    = prev_rx_q;
    prev_ry_d    = prev_ry_q;
    tick_d       = tick_q;
    evx_d        = evx_q;
    evy_d        = evy_q;
    neg_x_d      = neg_x_q;
    neg_y_d      = neg_y_q;
    losses_d     = losses_q;
    cx           = '0;
    cy           = '0;
    unique case (mode_q)
      MODE_REST: begin
        if (rx_abs < VALUE_W'(rest_rate_q) && ry_abs < VALUE_W'(rest_rate_q) &&
            rz_abs < VALUE_W'(rest_rate_q)) begin
          mode_d = MODE_SCAN;
        end
      end
      MODE_SCAN: begin
        cy           = (spd_ext > mx_ext) ? mx_ext : spd_ext;
        scan_angle_d = angle_new;
        if (angle_new <= SCAN_DONE_ANGLE) begin
          mode_d = MODE_SPIN;
        end
        if (in_q.sun_seen) begin
          mode_d = MODE_POINT;
        end
      end
      MODE_SPIN: begin
        cx = mx_ext;
        if (in_q.sun_seen) begin
          mode_d = MODE_POINT;
        end
      end
      MODE_POINT: begin
        if (check) begin
          prev_sx_d = in_q.sun_x;
          prev_sy_d = in_q.sun_y;
          prev_rx_d = in_q.rate_x;
          prev_ry_d = in_q.rate_y;
        end
        if (ev_y) begin
          if (evy_q >= flip_interval_q) begin
            neg_y_d = !neg_y_q;
            evy_d   = FLIP_W'(1);
          end else begin
            evy_d   = inc_sat8(evy_q);
          end
        end
        if (ev_x) begin
          if (evx_q >= flip_interval_q) begin
            neg_x_d = !neg_x_q;
            evx_d   = FLIP_W'(1);
          end else begin
            evx_d   = inc_sat8(evx_q);
          end
        end
        tick_d = check ? FLIP_W'(1) : inc_sat8(tick_q);
        cx = neg_x_d ? -cx_lin : cx_lin;
        cy = neg_y_d ? -cy_lin : cy_lin;
        if (!in_q.sun_seen) begin
          mode_d   = MODE_SCAN;
          losses_d = (losses_q == '1) ? losses_q : losses_q + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    out_d.cmd_x      = sat_cmd(cx);
    out_d.cmd_y      = sat_cmd(cy);
    out_d.cmd_z      = '0;
    out_d.mode_now   = mode_d;
    out_d.sun_echo   = in_q.sun_seen;
    out_d.loss_count = losses_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_REST;
      scan_angle_q <= ANGLE_W'(SCAN_START_RST);
      prev_sx_q    <= '0;
      prev_sy_q    <= '0;
      prev_rx_q    <= '0;
      prev_ry_q    <= '0;
      tick_q       <= '0;
      evx_q        <= '0;
      evy_q        <= '0;
      neg_x_q      <= 1'b1;
      neg_y_q      <= 1'b1;
      losses_q     <= '0;
      out_vld_q    <= 1'b0;
      out_q        <= '0;
    end else begin
      if (advance) begin
        mode_q       <= mode_d;
        scan_angle_q <= scan_angle_d;
        prev_sx_q    <= prev_sx_d;
        prev_sy_q    <= prev_sy_d;
        prev_rx_q    <= prev_rx_d;
        prev_ry_q    <= prev_ry_d;
        tick_q       <= tick_d;
        evx_q        <= evx_d;
        evy_q        <= evy_d;
        neg_x_q      <= neg_x_d;
        neg_y_q      <= neg_y_d;
        losses_q     <= losses_d;
        out_vld_q    <= 1'b1;
        out_q        <= out_d;
      end else if (out_ready_i) begin
        out_vld_q    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/sac_checker.sv]
// Port-level checker for the sun acquisition controller and its bind to the top level.
// Depends on sac_pkg and sun_acquisition_controller_assert.svh.
`default_nettype none

`include "sun_acquisition_controller_assert.svh"

module sac_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire sac_pkg::sac_out_t out_data_i
);
  import sac_pkg::*;

  logic [LOSS_W-1:0] last_loss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_loss_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      last_loss_q <= out_data_i.loss_count;
    end
  end

  `SAC_ASSERT_NEXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i)
  `SAC_ASSERT_NEXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(out_data_i))
  `SAC_ASSERT_NOW(a_cmd_z_zero, out_valid_i, out_data_i.cmd_z == '0)
  `SAC_ASSERT_NOW(a_loss_monotone, out_valid_i, out_data_i.loss_count >= last_loss_q)

endmodule

bind sun_acquisition_controller sac_checker u_sac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

[tb/sun_acquisition_controller_checker.sv]
// Result checker for the sun acquisition controller: mirrors its modes, scan angle,
// divergence counters and registers and compares every result in order.
// Depends on sac_pkg.
module sac_command_checker
  import sac_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  sac_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  sac_out_t              out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    errors_o
);

  typedef enum logic [MODE_W-1:0] {
    MODE_REST,
    MODE_SCAN,
    MODE_SPIN,
    MODE_POINT
  } mode_e;

  localparam longint ANGLE_FLOOR = -(longint'(1) <<< (ANGLE_W - 1));
  localparam longint CMD_HI      = (longint'(1) <<< (VALUE_W - 1)) - 1;
  localparam int     COUNT_TOP   = (1 << FLIP_W) - 1;
  localparam int     LOSS_TOP    = (1 << LOSS_W) - 1;

  longint   max_rate_q, gain_q, rest_q, scan_gain_q, step_q, flip_q;
  mode_e    mode_q;
  longint   angle_q, prev_sx, prev_sy, prev_rx, prev_ry;
  int       ticks_q, events_x, events_y, losses_q;
  bit       neg_x, neg_y;
  sac_out_t pending_cmds[$];
  int       fails;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int bump(input int c);
    return (c < COUNT_TOP) ? c + 1 : COUNT_TOP;
  endfunction

  function automatic logic [VALUE_W-1:0] clip_cmd(input longint v);
    if (v > CMD_HI) return VALUE_W'(CMD_HI);
    if (v < -CMD_HI - 1) return VALUE_W'(-CMD_HI - 1);
    return VALUE_W'(v);
  endfunction

  function automatic sac_out_t next_command(input sac_in_t t);
    longint   sx, sy, rx, ry, rz, mx, cx, cy, spd, trav, p, q;
    bit       same;
    sac_out_t r;
    sx = longint'($signed(t.sun_x));
    sy = longint'($signed(t.sun_y));
    rx = longint'($signed(t.rate_x));
    ry = longint'($signed(t.rate_y));
    rz = longint'($signed(t.rate_z));
    mx = max_rate_q;
    cx = 0;
    cy = 0;
    case (mode_q)
      MODE_REST: begin
        if (mag(rx) < rest_q && mag(ry) < rest_q && mag(rz) < rest_q) mode_q = MODE_SCAN;
      end
      MODE_SCAN: begin
        spd = (angle_q * scan_gain_q) >>> SCAN_SHIFT;
        trav = (mag(ry) * step_q) >>> TRAV_SHIFT;
        cy = (spd > mx) ? mx : spd;
        angle_q = angle_q - trav;
        if (angle_q < ANGLE_FLOOR) angle_q = ANGLE_FLOOR;
        if (angle_q <= longint'(SCAN_DONE_ANGLE)) mode_q = MODE_SPIN;
        if (t.sun_seen) mode_q = MODE_POINT;
      end
      MODE_SPIN: begin
        cx = mx;
        if (t.sun_seen) mode_q = MODE_POINT;
      end
      default: begin
        if (ticks_q >= flip_q) begin
          same = (prev_ry > 0 && ry > 0) || (prev_ry < 0 && ry < 0);
          ticks_q = 0;
          if (mag(sx) > mag(prev_sx) && mag(prev_ry) < mag(ry) && same) begin
            if (events_y >= flip_q) begin
              neg_y = !neg_y;
              events_y = 0;
            end
            events_y = bump(events_y);
          end
          if (mag(sy) > mag(prev_sy) && mag(prev_rx) < mag(rx) && same) begin
            if (events_x >= flip_q) begin
              neg_x = !neg_x;
              events_x = 0;
            end
            events_x = bump(events_x);
          end
          prev_sx = sx;
          prev_sy = sy;
          prev_rx = rx;
          prev_ry = ry;
        end
        ticks_q = bump(ticks_q);
        // saturated regions keep the opposite sign of the linear region on x
        p = (gain_q * sy) >>> SUN_FRAC;
        cx = (p > mx) ? mx : (p < -mx) ? -mx : -p;
        if (neg_x) cx = -cx;
        q = (gain_q * sx) >>> SUN_FRAC;
        cy = (q > mx) ? mx : (q < -mx) ? -mx : q;
        if (neg_y) cy = -cy;
        if (!t.sun_seen) begin
          mode_q = MODE_SCAN;
          if (losses_q < LOSS_TOP) losses_q++;
        end
      end
    endcase
    r.cmd_x = clip_cmd(cx);
    r.cmd_y = clip_cmd(cy);
    r.cmd_z = '0;
    r.mode_now = mode_q;
    r.sun_echo = t.sun_seen;
    r.loss_count = LOSS_W'(losses_q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sac_out_t want;
    if (!rst_ni) begin
      max_rate_q = longint'(MAX_RATE_RST);
      gain_q = longint'(POINTING_GAIN_RST);
      rest_q = longint'(REST_RATE_RST);
      scan_gain_q = longint'(SCAN_GAIN_RST);
      step_q = longint'(ANGLE_PER_TICK_RST);
      flip_q = longint'(FLIP_INTERVAL_RST);
      mode_q = MODE_REST;
      angle_q = longint'(SCAN_START_RST);
      prev_sx = 0;
      prev_sy = 0;
      prev_rx = 0;
      prev_ry = 0;
      ticks_q = 0;
      events_x = 0;
      events_y = 0;
      losses_q = 0;
      neg_x = 1'b1;
      neg_y = 1'b1;
      pending_cmds.delete();
      fails = 0;
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_cmds.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: unexpected result x=%0d y=%0d z=%0d mode=%0d sun=%0b loss=%0d",
                     $time, $signed(out_data_i.cmd_x), $signed(out_data_i.cmd_y),
                     $signed(out_data_i.cmd_z), out_data_i.mode_now, out_data_i.sun_echo,
                     out_data_i.loss_count);
          end
        end else begin
          want = pending_cmds.pop_front();
          if (out_data_i.cmd_x !== want.cmd_x || out_data_i.cmd_y !== want.cmd_y ||
              out_data_i.cmd_z !== want.cmd_z || out_data_i.mode_now !== want.mode_now ||
              out_data_i.sun_echo !== want.sun_echo ||
              out_data_i.loss_count !== want.loss_count) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch expected x=%0d y=%0d z=%0d mode=%0d sun=%0b loss=%0d",
                       $time, $signed(want.cmd_x), $signed(want.cmd_y), $signed(want.cmd_z),
                       want.mode_now, want.sun_echo, want.loss_count);
              $display("%0t:          actual   x=%0d y=%0d z=%0d mode=%0d sun=%0b loss=%0d",
                       $time, $signed(out_data_i.cmd_x), $signed(out_data_i.cmd_y),
                       $signed(out_data_i.cmd_z), out_data_i.mode_now,
                       out_data_i.sun_echo, out_data_i.loss_count);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) pending_cmds.push_back(next_command(in_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_RATE:            max_rate_q = longint'(cfg_data_i[RATE_CFG_W-1:0]);
          REG_POINTING_GAIN:       gain_q = longint'(cfg_data_i[RATE_CFG_W-1:0]);
          REG_REST_RATE:           rest_q = longint'(cfg_data_i[RATE_CFG_W-1:0]);
          REG_SCAN_START_ANGLE:    ; // keep the running scan angle
          REG_SCAN_GAIN:           scan_gain_q = longint'(cfg_data_i[GAIN_W-1:0]);
          REG_ANGLE_PER_RATE_TICK: step_q = longint'(cfg_data_i[GAIN_W-1:0]);
          REG_FLIP_INTERVAL:       flip_q = longint'(cfg_data_i[FLIP_W-1:0]);
          default:                 ;
        endcase
      end
      pending_o <= pending_cmds.size();
      errors_o <= fails;
    end
  end

endmodule

[tb/sun_acquisition_controller_test.sv]
// Top of the sun acquisition controller testbench: clock, reset, sensor tick and
// register stimulus, result back-pressure and the verdict.
// Depends on sac_pkg, sun_acquisition_controller and sac_command_checker.
module sun_acquisition_controller_test;
  import sac_pkg::*;

  localparam logic signed [VALUE_W-1:0] TOP_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] TOP_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0]      REG_UNUSED = '1;
  localparam int                        PHASE_ITEMS = 110;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  sac_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  sac_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int pending;
  int fails;
  int sent;
  bit idle_on;
  bit stall_on;

  sun_acquisition_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  sac_command_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (fails)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 9);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return TOP_NEG;
      1: return TOP_POS;
      2: return '0;
      3: return VALUE_W'($urandom_range(0, 2)) - 1'b1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] ramp(input longint m, input bit neg);
    if (m > longint'(TOP_POS)) return neg ? TOP_NEG : TOP_POS;
    return VALUE_W'(neg ? -m : m);
  endfunction

  task automatic send_tick(input logic signed [VALUE_W-1:0] sx, sy, rx, ry, rz,
                           input bit seen);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{sun_x: sx, sun_y: sy, rate_x: rx, rate_y: ry, rate_z: rz,
                   sun_seen: seen};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // Hold a sun and rate trend so the divergence checks see growing errors.
  task automatic sweep_point(input int len);
    longint step_s, step_r;
    bit     nx, ny, nrx, nry;
    int     k;
    {nx, ny, nrx, nry} = 4'($urandom);
    step_s = $urandom_range(1, 1 << 18);
    step_r = $urandom_range(1, 1 << 18);
    for (k = 1; k <= len; k++) begin
      if ($urandom_range(0, 11) == 0) nry = !nry;
      send_tick(ramp(k * step_s + $urandom_range(0, 255), nx),
                ramp(k * step_s + $urandom_range(0, 255), ny),
                ramp(k * step_r + $urandom_range(0, 255), nrx),
                ramp(k * step_r + $urandom_range(0, 255), nry),
                pick_value(), $urandom_range(0, 24) != 0);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_regs(input int mr, pg, rr, ssa, sg, apt, fi);
    wait_idle();
    cfg_write(REG_MAX_RATE, mr);
    cfg_write(REG_POINTING_GAIN, pg);
    cfg_write(REG_REST_RATE, rr);
    cfg_write(REG_SCAN_START_ANGLE, ssa);
    cfg_write(REG_SCAN_GAIN, sg);
    cfg_write(REG_ANGLE_PER_RATE_TICK, apt);
    cfg_write(REG_FLIP_INTERVAL, fi);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        hold = gap_len();
      end else begin
        out_ready_i <= 1'b1;
        hold = $urandom_range(0, 6);
      end
    end
  end

  initial begin
    int ph, k, stop;
    sent = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rest: one rate too high, one at the threshold, one at the most negative value, then all just below
    send_tick(0, 0, TOP_POS, 0, 0, 1'b1);
    send_tick(0, 0, 0, -732, 0, 1'b0);
    send_tick(TOP_NEG, TOP_POS, 0, 0, TOP_NEG, 1'b1);
    send_tick(TOP_POS, TOP_NEG, 731, -731, 731, 1'b1);
    // scan until the angle runs out, then spin
    send_tick(0, 0, 0, TOP_NEG, 0, 1'b0);
    send_tick(0, 0, 0, TOP_POS, 0, 1'b0);
    send_tick(0, 0, 0, TOP_POS, 0, 1'b0);
    send_tick(0, 0, 0, TOP_POS, 0, 1'b0);
    send_tick(TOP_POS, TOP_POS, TOP_POS, TOP_POS, TOP_POS, 1'b0);
    // point through one divergence check
    send_tick(1, -1, 1, 1, 0, 1'b1);
    for (k = 1; k <= 7; k++) begin
      send_tick(VALUE_W'(k << 20), VALUE_W'(-(k << 20)), VALUE_W'(k << 19),
                VALUE_W'(k << 19), 0, 1'b1);
    end
    send_tick(TOP_NEG, TOP_POS, 0, 0, 0, 1'b0);
    send_tick(0, 0, 0, 0, 0, 1'b1);
    send_tick(0, 0, 0, 0, 0, 1'b0);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_regs(8388607, 8388607, 8388607, 23592960, 16777215, 16777215, 255);
        2: set_regs(0, 0, 0, 0, 0, 0, 0);
        3: set_regs($urandom_range(0, 1 << 20), $urandom_range(1 << 20, 8388607),
                    $urandom_range(0, 8388607), $urandom_range(0, 23592960),
                    $urandom_range(0, 16777215), 16777215, 1);
        4: set_regs($urandom_range(0, 8388607), $urandom_range(0, 8388607),
                    $urandom_range(0, 8388607), $urandom_range(0, 23592960),
                    $urandom_range(0, 16777215), $urandom_range(0, 16777215),
                    $urandom_range(0, 6));
        5: begin
          wait_idle();
          cfg_write(REG_UNUSED, $urandom);
          cfg_valid_i <= 1'b0;
          set_regs(int'(MAX_RATE_RST), int'(POINTING_GAIN_RST), int'(REST_RATE_RST),
                   int'(SCAN_START_RST), int'(SCAN_GAIN_RST), int'(ANGLE_PER_TICK_RST),
                   int'(FLIP_INTERVAL_RST));
        end
        default: ;
      endcase
      stop = sent + PHASE_ITEMS;
      while (sent < stop) begin
        idle_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0, 1: repeat ($urandom_range(1, 5)) begin
            send_tick(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                      1'($urandom_range(0, 1)));
          end
          2, 3: repeat ($urandom_range(1, 12)) begin
            send_tick(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                      $urandom_range(0, 9) == 0);
          end
          default: sweep_point($urandom_range(8, 48));
        endcase
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
